// ===== design/clll_pkg.sv =====
`default_nettype none

package clll_pkg;

	// default list capacity
	localparam int DEPTH_DEFAULT = 32;

	// word field widths
	localparam int W_OP     = 2;
	localparam int W_BYTE   = 8;
	localparam int W_STATUS = 3;
	localparam int W_COUNT  = 6;

	// operation codes
	localparam logic [W_OP-1:0] OP_INSERT   = 2'd0;
	localparam logic [W_OP-1:0] OP_REMOVE   = 2'd1;
	localparam logic [W_OP-1:0] OP_READ_FWD = 2'd2;
	localparam logic [W_OP-1:0] OP_READ_BWD = 2'd3;

	// result status codes
	localparam logic [W_STATUS-1:0] ST_DONE      = 3'd0;
	localparam logic [W_STATUS-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [W_STATUS-1:0] ST_FULL      = 3'd2;
	localparam logic [W_STATUS-1:0] ST_EMPTY     = 3'd3;

	// per-cycle command to the row of cells
	typedef struct packed {
		logic shift;	// every cell takes its lower neighbour
		logic pull;		// cells at or above pos take their upper neighbour
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/clll_req_if.sv =====
`default_nettype none

interface clll_req_if import clll_pkg::*;;
	logic              valid;
	logic              ready;
	logic [W_OP-1:0]   operation;
	logic [W_BYTE-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// ===== design/clll_rsp_if.sv =====
`default_nettype none

interface clll_rsp_if import clll_pkg::*;;
	logic                valid;
	logic                ready;
	logic [W_STATUS-1:0] status;
	logic [W_BYTE-1:0]   item;
	logic                last;
	logic [W_COUNT-1:0]  removed_count;

	modport source (output valid, output status, output item, output last,
		output removed_count, input ready);
	modport sink (input valid, input status, input item, input last,
		input removed_count, output ready);
endinterface

`default_nettype wire

// ===== design/char_list_insert_remove_walk.sv =====
`default_nettype none

// Channel  Dir  Fields                                   Word
// req      in   operation[1:0] value[7:0]                one command
// rsp      out  status[2:0] item[7:0] last removed_count  one result
//
// Insert, and reads of an empty list, finish in the cycle they are taken.
// Remove inspects one stored entry per cycle.
// Reads give one entry per cycle while rsp is ready.
// A new command is taken only when idle and the result register is free.
// arst_n clears the control state; stored bytes need no reset.
module char_list_insert_remove_walk import clll_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire        clk,
	input  wire        arst_n,
	clll_req_if.sink   req,
	clll_rsp_if.source rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_READ
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       rem_q;
	logic [CW-1:0]       removed_q;
	logic [IW-1:0]       idx_q;
	logic                bwd_q;
	logic [W_BYTE-1:0]   val_q;
	logic                out_valid_q;
	logic [W_STATUS-1:0] out_status_q;
	logic [W_BYTE-1:0]   out_item_q;
	logic                out_last_q;
	logic [W_COUNT-1:0]  out_count_q;

	logic [W_BYTE-1:0] cell_data [DEPTH];
	logic [W_BYTE-1:0] cell_sel;
	cell_ctl_t         ctl;
	logic              out_free;
	logic              req_fire;
	logic              is_full;
	logic              out_load;

	// handshake and cell commands
	assign cell_sel  = cell_data[idx_q];
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign is_full   = (occ_q == CW'(DEPTH));
	assign ctl.shift = req_fire && (req.operation == OP_INSERT) && !is_full;
	assign ctl.pull  = (state_q == S_REMOVE) && (rem_q != '0) && (cell_sel == val_q);

	// a result word is loaded in this cycle
	assign out_load = (req_fire && ((req.operation == OP_INSERT) ||
		(((req.operation == OP_READ_FWD) || (req.operation == OP_READ_BWD)) &&
		(occ_q == '0)))) ||
		((state_q == S_REMOVE) && (rem_q == '0) && out_free) ||
		((state_q == S_READ) && out_free);

	// row of storage cells, index 0 holds the newest byte
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W_BYTE-1:0] prev_d;
		logic [W_BYTE-1:0] next_d;
		if (i == 0) begin : g_head
			assign prev_d = req.value;
		end else begin : g_body
			assign prev_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		clll_cell #(
			.IW    (IW),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (idx_q),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			rem_q        <= '0;
			removed_q    <= '0;
			idx_q        <= '0;
			bwd_q        <= 1'b0;
			val_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
			out_item_q   <= '0;
			out_last_q   <= 1'b0;
			out_count_q  <= '0;
		end else begin
			// raise on a new load, drop a word once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.operation)
							OP_INSERT: begin
								out_status_q <= is_full ? ST_FULL : ST_DONE;
								out_item_q   <= '0;
								out_last_q   <= 1'b1;
								out_count_q  <= '0;
								if (!is_full) begin
									occ_q <= occ_q + CW'(1);
								end
							end
							OP_REMOVE: begin
								val_q     <= req.value;
								idx_q     <= '0;
								rem_q     <= occ_q;
								removed_q <= '0;
								state_q   <= S_REMOVE;
							end
							OP_READ_FWD, OP_READ_BWD: begin
								if (occ_q == '0) begin
									out_status_q <= ST_EMPTY;
									out_item_q   <= '0;
									out_last_q   <= 1'b1;
									out_count_q  <= '0;
								end else begin
									bwd_q   <= (req.operation == OP_READ_BWD);
									idx_q   <= (req.operation == OP_READ_BWD) ?
										IW'(occ_q - CW'(1)) : '0;
									rem_q   <= occ_q;
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_REMOVE: begin
					// inspect one entry; on a match the cells close the gap
					if (rem_q != '0) begin
						rem_q <= rem_q - CW'(1);
						if (ctl.pull) begin
							occ_q     <= occ_q - CW'(1);
							removed_q <= removed_q + CW'(1);
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end else if (out_free) begin
						out_status_q <= (removed_q == '0) ? ST_NOT_FOUND : ST_DONE;
						out_item_q   <= '0;
						out_last_q   <= 1'b1;
						out_count_q  <= W_COUNT'(removed_q);
						state_q      <= S_IDLE;
					end
				end
				S_READ: begin
					// hand out one entry per free slot
					if (out_free) begin
						out_status_q <= ST_DONE;
						out_item_q   <= cell_sel;
						out_last_q   <= (rem_q == CW'(1));
						out_count_q  <= '0;
						rem_q        <= rem_q - CW'(1);
						idx_q        <= bwd_q ? (idx_q - IW'(1)) : (idx_q + IW'(1));
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.item          = out_item_q;
	assign rsp.last          = out_last_q;
	assign rsp.removed_count = out_count_q;

	// occupancy stays within capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy beyond capacity");

	// removal never grows the list
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REMOVE) |=> (occ_q <= $past(occ_q)))
		else $error("occupancy grew during removal");

	// a read in progress always has entries left to give
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (rem_q != '0))
		else $error("read walk with nothing left");

	// a not-found result carries no deletions
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_NOT_FOUND)) |-> (out_count_q == '0))
		else $error("not found with deletions");

	// count of deletions and entries left to inspect never exceeds capacity
	a_remove_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REMOVE) |-> ((removed_q + rem_q) <= CW'(DEPTH)))
		else $error("removal walk count out of range");

endmodule

`default_nettype wire

// ===== design/clll_cell.sv =====
`default_nettype none

module clll_cell import clll_pkg::*; #(
	parameter int IW    = 5,
	parameter int INDEX = 0
) (
	input  wire              clk,
	input  wire cell_ctl_t   ctl,
	input  wire [IW-1:0]     pos,
	input  wire [W_BYTE-1:0] prev_data,
	input  wire [W_BYTE-1:0] next_data,
	output logic [W_BYTE-1:0] data
);

	logic [W_BYTE-1:0] data_q;

	// shift towards the tail on insert, close the gap on removal, else hold
	always_ff @(posedge clk) begin
		priority if (ctl.shift) begin
			data_q <= prev_data;
		end else if (ctl.pull && (IW'(INDEX) >= pos)) begin
			data_q <= next_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire
